// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: field widths,
// command and register codes, the decoded command item and the back-end
// sequencer states.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int POS_W    = 11;
    localparam int COLOR_W  = 4;
    localparam int CELL_W   = CHAR_W + ATTR_W;

    // Stream bus widths (byte multiples)
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;

    // APB port
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_FG = 1'b0;
    localparam logic REG_BG = 1'b1;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Characters and blank cell
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
    localparam logic [ATTR_W-1:0] BLANK_ATTR   = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL   = {BLANK_ATTR, BLANK_CHAR};

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Decoded operation
    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CHAR_W-1:0] char_code;
        logic [POS_W-1:0]  cell_index;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_SWEEP,
        ST_FLUSH,
        ST_IDLE,
        ST_RESULT
    } back_state_t;

endpackage

// ===== rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input items, decodes them into operations and holds them in a
// short queue for the back end.
// ----------------------------------------------------------------------------
module tcw_front #(
    parameter int CELL_COUNT = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept_en,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tcw_pkg::CMD_W-1:0]   s_command,
    input  logic [tcw_pkg::CHAR_W-1:0]  s_char_code,
    input  logic [tcw_pkg::POS_W-1:0]   s_cell_index,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output tcw_pkg::cmd_t               cmd
);
    import tcw_pkg::*;

    localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              in_cmd;
    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    // Decode the command; an out-of-range read changes nothing
    always_comb begin
        in_cmd.char_code  = s_char_code;
        in_cmd.cell_index = s_cell_index;
        unique case (s_command)
            CMD_PUT:   in_cmd.op = (s_char_code == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
            CMD_CLEAR: in_cmd.op = OP_CLEAR;
            CMD_READ:  in_cmd.op = (32'(s_cell_index) < 32'(CELL_COUNT)) ? OP_READ : OP_NOP;
            default:   in_cmd.op = OP_NOP;
        endcase
    end

    assign s_tready  = accept_en && (count_reg != CNT_W'(QUEUE_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_valid && cmd_ready;

    // Queue pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue payload
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Carries out decoded operations on the screen store: cell writes, cursor
// moves, reads, and sweeps over all cells for scroll, clear and reset.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [tcw_pkg::COLOR_W-1:0] fg_color,
    input  logic [tcw_pkg::COLOR_W-1:0] bg_color,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  tcw_pkg::cmd_t               cmd,
    output logic                        accept_en,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [tcw_pkg::POS_W-1:0]   m_cursor_pos,
    output logic [tcw_pkg::CHAR_W-1:0]  m_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]  m_cell_attr
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(COLUMNS);
    localparam int RW         = $clog2(ROWS);

    function automatic logic [POS_W-1:0] pos_field(input logic [AW-1:0] p);
        logic [AW+POS_W-1:0] w;
        w = {{POS_W{1'b0}}, p};
        return w[POS_W-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [POS_W-1:0] idx);
        logic [AW+POS_W-1:0] w;
        w = {{AW{1'b0}}, idx};
        return w[AW-1:0];
    endfunction

    back_state_t        state_reg, state_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      sweep_reg, sweep_next;
    logic               copy_reg, copy_next;
    logic               report_reg, report_next;
    logic               pend_valid_reg, pend_valid_next;
    logic               pend_copy_reg, pend_copy_next;
    logic [AW-1:0]      pend_addr_reg, pend_addr_next;
    logic               hit_reg, hit_next;
    logic               init_done_reg, init_done_next;
    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic [ATTR_W-1:0]  out_attr_reg, out_attr_next;

    logic               ram_wr_en, ram_rd_en;
    logic [AW-1:0]      ram_wr_addr, ram_rd_addr;
    logic [CELL_W-1:0]  ram_wr_data, ram_rd_data;

    logic               out_free, take;
    logic               at_bottom, at_last_col, last_sweep;
    logic [AW-1:0]      row_start, next_line_pos;
    logic [AW:0]        sweep_src;
    logic               load_out, copy_issue;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign out_free      = !out_valid_reg || m_tready;
    assign take          = (state_reg == ST_IDLE) && cmd_valid && out_free;
    assign at_bottom     = (row_reg == RW'(ROWS - 1));
    assign at_last_col   = (col_reg == CW'(COLUMNS - 1));
    assign last_sweep    = (sweep_reg == AW'(CELL_COUNT - 1));
    assign row_start     = pos_reg - AW'(col_reg);
    assign next_line_pos = row_start + AW'(COLUMNS);
    assign sweep_src     = {1'b0, sweep_reg} + (AW + 1)'(COLUMNS);

    assign accept_en    = init_done_reg;
    assign m_tvalid     = out_valid_reg;
    assign m_cursor_pos = out_pos_reg;
    assign m_cell_char  = out_char_reg;
    assign m_cell_attr  = out_attr_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                if (last_sweep) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = report_reg ? ST_RESULT : ST_IDLE;
            end
            ST_IDLE: begin
                if (take) begin
                    unique case (cmd.op)
                        OP_PUT:     if (at_last_col && at_bottom) state_next = ST_SWEEP;
                        OP_NEWLINE: if (at_bottom) state_next = ST_SWEEP;
                        OP_CLEAR:   state_next = ST_SWEEP;
                        OP_READ:    state_next = ST_RESULT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory control and result register
    always_comb begin
        col_next        = col_reg;
        row_next        = row_reg;
        pos_next        = pos_reg;
        sweep_next      = sweep_reg;
        copy_next       = copy_reg;
        report_next     = report_reg;
        pend_valid_next = pend_valid_reg;
        pend_copy_next  = pend_copy_reg;
        pend_addr_next  = pend_addr_reg;
        hit_next        = hit_reg;
        init_done_next  = init_done_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_pos_next    = out_pos_reg;
        out_char_next   = out_char_reg;
        out_attr_next   = out_attr_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = pend_addr_reg;
        ram_wr_data     = pend_copy_reg ? ram_rd_data : BLANK_CELL;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = sweep_src[AW-1:0];
        cmd_ready       = 1'b0;
        load_out        = 1'b0;
        copy_issue      = copy_reg && (sweep_reg < AW'(COPY_COUNT));

        unique case (state_reg)
            // Walk all cells: read one row below, write one cell behind
            ST_SWEEP: begin
                ram_wr_en       = pend_valid_reg;
                ram_rd_en       = copy_issue;
                pend_valid_next = 1'b1;
                pend_addr_next  = sweep_reg;
                pend_copy_next  = copy_issue;
                sweep_next      = last_sweep ? '0 : sweep_reg + 1'b1;
            end
            // Retire the last pending write of the sweep
            ST_FLUSH: begin
                ram_wr_en       = pend_valid_reg;
                pend_valid_next = 1'b0;
                init_done_next  = 1'b1;
            end
            ST_IDLE: begin
                cmd_ready = out_free;
                if (take) begin
                    unique case (cmd.op)
                        OP_PUT, OP_NEWLINE: begin
                            if (cmd.op == OP_PUT) begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = pos_reg;
                                ram_wr_data = {bg_color, fg_color, cmd.char_code};
                            end
                            if (cmd.op == OP_PUT && !at_last_col) begin
                                col_next = col_reg + 1'b1;
                                pos_next = pos_reg + 1'b1;
                                load_out = 1'b1;
                            end else begin
                                col_next = '0;
                                if (at_bottom) begin
                                    pos_next    = row_start;
                                    sweep_next  = '0;
                                    copy_next   = 1'b1;
                                    report_next = 1'b1;
                                end else begin
                                    row_next = row_reg + 1'b1;
                                    pos_next = next_line_pos;
                                    load_out = 1'b1;
                                end
                            end
                        end
                        OP_CLEAR: begin
                            col_next    = '0;
                            row_next    = '0;
                            pos_next    = '0;
                            sweep_next  = '0;
                            copy_next   = 1'b0;
                            report_next = 1'b1;
                        end
                        OP_READ: begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = cell_addr(cmd.cell_index);
                            hit_next    = 1'b1;
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
                if (load_out) begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_field(pos_next);
                    out_char_next  = '0;
                    out_attr_next  = '0;
                end
            end
            // Deliver the result of a read or a sweep
            ST_RESULT: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_pos_next   = pos_field(pos_reg);
                    out_char_next  = hit_reg ? ram_rd_data[CHAR_W-1:0] : '0;
                    out_attr_next  = hit_reg ? ram_rd_data[CELL_W-1:CHAR_W] : '0;
                    hit_next       = 1'b0;
                    report_next    = 1'b0;
                end
            end
            default: begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            col_reg        <= '0;
            row_reg        <= '0;
            pos_reg        <= '0;
            sweep_reg      <= '0;
            copy_reg       <= 1'b0;
            report_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_copy_reg  <= 1'b0;
            hit_reg        <= 1'b0;
            init_done_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pos_reg        <= pos_next;
            sweep_reg      <= sweep_next;
            copy_reg       <= copy_next;
            report_reg     <= report_next;
            pend_valid_reg <= pend_valid_next;
            pend_copy_reg  <= pend_copy_next;
            hit_reg        <= hit_next;
            init_done_reg  <= init_done_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        out_pos_reg   <= out_pos_next;
        out_char_reg  <= out_char_next;
        out_attr_reg  <= out_attr_next;
    end

endmodule

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine with a character/attribute screen store.
//
// Input stream (s_*): one item per command. s_tuser carries the command
// (put, clear, read); s_tdata carries the character byte and the cell index.
// Result stream (m_*): exactly one item per input item, in order, with the
// cursor position after the command and, for a read, the cell contents.
// Colors for written cells come from two APB registers (fg at 0x0, bg at 0x4).
//
// Puts and newlines sustain one item per cycle while the result side keeps
// up and no sweep runs; a read passes through a result state before the
// back end takes the next item. A clear, and a newline or line wrap on the
// bottom row, sweep the whole store through the single RAM port pair; the
// back end takes no commands meanwhile. After reset the store is cleared to
// blanks, with s_tready low until the sweep is done; the APB port works
// throughout. A stalled result register holds its item; the two-entry command
// queue keeps taking input meanwhile, until it is full.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // APB configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tcw_pkg::IN_DATA_W-1:0]   s_tdata,   // char_code[7:0], cell_index[18:8]
    input  logic [tcw_pkg::CMD_W-1:0]       s_tuser,   // command[1:0]
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcw_pkg::OUT_DATA_W-1:0]  m_tdata    // cursor_pos[10:0], cell_char[18:11],
                                                       // cell_attr[26:19]
);
    import tcw_pkg::*;

    logic [COLOR_W-1:0] fg_reg, fg_next;
    logic [COLOR_W-1:0] bg_reg, bg_next;
    logic               cfg_write;
    logic               accept_en;
    logic               cmd_valid, cmd_ready;
    cmd_t               cmd;
    logic [POS_W-1:0]   res_pos;
    logic [CHAR_W-1:0]  res_char;
    logic [ATTR_W-1:0]  res_attr;

    // Color registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        fg_next = fg_reg;
        bg_next = bg_reg;
        if (cfg_write) begin
            unique case (paddr[REG_SEL_BIT])
                REG_FG:  fg_next = pwdata[COLOR_W-1:0];
                REG_BG:  bg_next = pwdata[COLOR_W-1:0];
                default: fg_next = fg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end else begin
            fg_reg <= fg_next;
            bg_reg <= bg_next;
        end
    end

    assign prdata = (paddr[REG_SEL_BIT] == REG_BG) ? APB_DATA_W'(bg_reg) : APB_DATA_W'(fg_reg);

    tcw_front #(
        .CELL_COUNT (COLUMNS * ROWS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept_en    (accept_en),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_command    (s_tuser),
        .s_char_code  (s_tdata[CHAR_W-1:0]),
        .s_cell_index (s_tdata[CHAR_W+POS_W-1:CHAR_W]),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fg_color     (fg_reg),
        .bg_color     (bg_reg),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .accept_en    (accept_en),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_cursor_pos (res_pos),
        .m_cell_char  (res_char),
        .m_cell_attr  (res_attr)
    );

    assign m_tdata = OUT_DATA_W'({res_attr, res_char, res_pos});

endmodule
